// ----- sv/wto_pkg.sv -----
`timescale 1ns / 1ps

package wto_pkg;

  localparam int FIELD_CH_W   = 3;
  localparam int FIELD_CODE_W = 8;
  localparam int SAMPLE_W     = 16;
  localparam int STEP_W       = 32;
  localparam int PHASE_W      = 32;
  localparam int GAIN_W       = 13;
  localparam int SEL_W        = 3;
  localparam int DK_W         = 8;
  localparam int PROD_W       = GAIN_W + 1 + DK_W;
  localparam int TERM_W       = 14;

  localparam logic [FIELD_CODE_W-1:0] FREQ_BIAS  = 8'h20;
  localparam logic [FIELD_CODE_W-1:0] OVT_AMP_DN = 8'd24;
  localparam logic [FIELD_CODE_W-1:0] OVT_SQUARE = 8'h80;
  localparam logic [FIELD_CH_W-1:0]   OVT_SRC_N  = 3'd2;
  localparam logic [FIELD_CODE_W-1:0] PULSE_EDGE = 8'd51;
  localparam logic [FIELD_CODE_W-1:0] WAVE_MID   = 8'd128;
  localparam logic [FIELD_CODE_W-1:0] WAVE_LO    = 8'h40;
  localparam logic [FIELD_CODE_W-1:0] WAVE_HI    = 8'hC0;
  localparam int                      SAT_MAX    = 32767;

  localparam logic [SEL_W-1:0] WAVE_TRAP   = 3'd0;
  localparam logic [SEL_W-1:0] WAVE_SINE   = 3'd1;
  localparam logic [SEL_W-1:0] WAVE_SQUARE = 3'd2;
  localparam logic [SEL_W-1:0] WAVE_PULSE  = 3'd3;
  localparam logic [SEL_W-1:0] WAVE_NOISE  = 3'd4;

  typedef struct packed {
    logic [SEL_W-1:0]  sel;
    logic [GAIN_W-1:0] gain;
    logic [STEP_W-1:0] step;
  } chan_cfg_t;

  typedef logic [6:0] cosq_t [64];
  typedef logic [7:0] noise_rom_t [256];

  localparam cosq_t COS_QUARTER = '{
    7'd64, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63, 7'd63,
    7'd62, 7'd62, 7'd62, 7'd61, 7'd61, 7'd60, 7'd60, 7'd59,
    7'd59, 7'd58, 7'd57, 7'd57, 7'd56, 7'd55, 7'd54, 7'd54,
    7'd53, 7'd52, 7'd51, 7'd50, 7'd49, 7'd48, 7'd47, 7'd46,
    7'd45, 7'd44, 7'd42, 7'd41, 7'd40, 7'd39, 7'd38, 7'd36,
    7'd35, 7'd34, 7'd32, 7'd31, 7'd30, 7'd28, 7'd27, 7'd25,
    7'd24, 7'd23, 7'd21, 7'd20, 7'd18, 7'd17, 7'd15, 7'd14,
    7'd12, 7'd10, 7'd9,  7'd7,  7'd6,  7'd4,  7'd3,  7'd1
  };

  // 16-bit Galois LFSR, one step per entry, evaluated at elaboration
  function automatic noise_rom_t gen_noise();
    logic [15:0] lfsr;
    noise_rom_t  rom;
    lfsr = 16'hACE1;
    for (int i = 0; i < 256; i++) begin
      if (lfsr[0]) begin
        lfsr = (lfsr >> 1) ^ 16'hB400;
      end else begin
        lfsr = lfsr >> 1;
      end
      rom[i] = WAVE_LO + {1'b0, lfsr[6:0]};
    end
    return rom;
  endfunction

  localparam noise_rom_t NOISE_ROM = gen_noise();

  function automatic logic [7:0] sine_value(logic [7:0] i);
    logic [7:0] ni;
    logic [7:0] v;
    ni = 8'd0 - i;
    if (i < 8'd64) begin
      v = 8'd128 + {1'b0, COS_QUARTER[i[5:0]]};
    end else if (i == 8'd64) begin
      v = 8'd127;
    end else if (i < 8'd128) begin
      v = 8'd127 - {1'b0, COS_QUARTER[ni[5:0]]};
    end else if (i == 8'd128) begin
      v = 8'd64;
    end else if (i < 8'd192) begin
      v = 8'd127 - {1'b0, COS_QUARTER[i[5:0]]};
    end else if (i == 8'd192) begin
      v = 8'd128;
    end else begin
      v = 8'd128 + {1'b0, COS_QUARTER[ni[5:0]]};
    end
    return v;
  endfunction

  function automatic logic [7:0] wave_value(logic [SEL_W-1:0] sel, logic [7:0] i);
    logic [7:0] v;
    unique case (sel)
      WAVE_TRAP: begin
        if (i < 8'd64) begin
          v = WAVE_HI;
        end else if (i < 8'd128) begin
          v = WAVE_HI - {1'b0, i[5:0], 1'b0};
        end else if (i < 8'd192) begin
          v = WAVE_LO;
        end else begin
          v = WAVE_LO + {1'b0, i[5:0], 1'b0};
        end
      end
      WAVE_SINE:   v = sine_value(i);
      WAVE_SQUARE: v = i[7] ? WAVE_LO : WAVE_HI;
      WAVE_PULSE:  v = (i > PULSE_EDGE) ? WAVE_LO : WAVE_HI;
      WAVE_NOISE:  v = NOISE_ROM[i];
      default:     v = WAVE_MID;
    endcase
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] step_of(logic [7:0] idx);
    return (32'h8000_0000 - {2'b00, idx[4:0], 25'd0}) >> idx[7:5];
  endfunction

  function automatic logic [GAIN_W-1:0] gain_of(logic [7:0] a);
    logic [GAIN_W-1:0] g;
    if (a[5:0] == 6'd0) begin
      g = '0;
    end else begin
      g = {9'd0, 1'b1, a[2:0]} << ({1'b0, a[5:3]} + 4'd2);
    end
    return g;
  endfunction

  function automatic chan_cfg_t chan_cfg(logic [7:0] f, logic [7:0] a, logic [7:0] adj);
    logic signed [9:0] fri;
    logic [7:0]        fri8;
    chan_cfg_t         c;
    fri = $signed({2'b00, f}) - $signed({2'b00, FREQ_BIAS}) + $signed({{2{adj[7]}}, adj});
    if (fri < 10'sd0) begin
      fri8 = 8'd0;
    end else if (fri > 10'sd255) begin
      fri8 = 8'd255;
    end else begin
      fri8 = fri[7:0];
    end
    c.step = step_of(fri8);
    c.gain = gain_of(a);
    c.sel  = {1'b0, a[7:6]};
    if (a[7:6] == 2'd3 && fri8 < FREQ_BIAS) begin
      c.sel  = WAVE_NOISE;
      c.step = step_of({fri8[5:0], 2'b00}) >> 8;
    end
    return c;
  endfunction

endpackage

// ----- sv/wto_ram.sv -----
`timescale 1ns / 1ps

module wto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wavetable_oscillator_bank.sv -----
`timescale 1ns / 1ps
// Eight-channel wavetable oscillator bank.
// in_*: tuser is the mode (0 set up one channel, 1 sample tick); tdata carries
//   channel, freq_code and amp_code. Setting channel 0 or 1 also sets channel 6 or 7
//   as its overtone; a channel above 5 is accepted and ignored.
// cfg_*: one write-only register, freq_adjust, taken on any cycle; write it
//   only while the bank is idle.
// out_*: one 16-bit saturated sample per tick item; set-up items give none.
// Per-channel phase and set-up words live in two RAMs with registered reads.
// A set-up item writes RAM in ST_SET_MAIN, and again in ST_SET_OVT for an overtone.
// A tick walks the channels one RAM read per cycle through a three-stage
//   wave / multiply / accumulate pipe; once the pipe drains, ST_FIN loads the
//   saturated sum into the sample register.
// Input ready is high only while the sequencer is idle. A sample still
//   waiting on out_tready does not block the next item; a later tick holds in
//   its final state until the output register is free.
// Reset (rst_n, synchronous) clears every channel's phase, step, gain and
//   wave through per-entry valid bits, no clearing pass, and freq_adjust.
module wavetable_oscillator_bank
  import wto_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // channel[2:0], freq_code[10:3], amp_code[18:11], zero pad
  input  logic        in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sample[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = $clog2(NUM_CHANNELS);
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int ACC_W = TERM_W + $clog2(NUM_CHANNELS);
  localparam int CFG_W = $bits(chan_cfg_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_MAIN,
    ST_SET_OVT,
    ST_TICK,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]              adj_r;
  logic [FIELD_CH_W-1:0]   it_ch_r;
  logic [FIELD_CODE_W-1:0] it_f_r;
  logic [FIELD_CODE_W-1:0] it_a_r;

  logic [CNT_W-1:0]        cnt_r;
  logic [NUM_CHANNELS-1:0] ph_vld_r;
  logic [NUM_CHANNELS-1:0] cf_vld_r;

  logic                    s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]        s1_idx_r;
  logic                    s1_ph_ok_r, s1_cf_ok_r;
  logic signed [DK_W-1:0]  dk_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic                    out_tvalid_r;
  logic [SAMPLE_W-1:0]     out_tdata_r;

  logic                    in_acc;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_idx;
  logic                    drain_done;

  logic                    ph_we;
  logic [PHASE_W-1:0]      ph_wdata, ph_rdata, ph_cur;
  logic                    cf_we;
  logic [IDX_W-1:0]        cf_waddr;
  logic [CFG_W-1:0]        cf_wdata, cf_rdata;
  chan_cfg_t               cf_cur;

  logic [FIELD_CODE_W-1:0] ovt_f, ovt_a;
  logic [8:0]              f_sum;
  logic [7:0]              wave;
  logic signed [8:0]       dk_wide;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] term;
  logic [SAMPLE_W-1:0]     sample_sat;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // channel walk
  assign rd_en      = (state_r == ST_TICK) && (cnt_r < CNT_W'(NUM_CHANNELS));
  assign rd_idx     = cnt_r[IDX_W-1:0];
  assign drain_done = (cnt_r == CNT_W'(NUM_CHANNELS)) && !s1_v_r && !s2_v_r && !s3_v_r;

  // stage 1: wave lookup and phase write-back
  assign ph_cur   = s1_ph_ok_r ? ph_rdata : '0;
  assign cf_cur   = s1_cf_ok_r ? chan_cfg_t'(cf_rdata) : '0;
  assign wave     = wave_value(cf_cur.sel, ph_cur[PHASE_W-1 -: 8]);
  assign dk_wide  = $signed({1'b0, wave}) - $signed({1'b0, WAVE_MID});
  assign ph_we    = s1_v_r;
  assign ph_wdata = ph_cur + cf_cur.step;

  // stage 2 and 3: scale and floor-accumulate
  assign prod = $signed({1'b0, gain_r}) * dk_r;
  assign term = ACC_W'(prod_r >>> 6);

  always_comb begin
    if (acc_r > ACC_W'(SAT_MAX)) begin
      sample_sat = SAMPLE_W'(SAT_MAX);
    end else if (acc_r < -ACC_W'(SAT_MAX)) begin
      sample_sat = SAMPLE_W'(-SAT_MAX);
    end else begin
      sample_sat = acc_r[SAMPLE_W-1:0];
    end
  end

  // set-up writes
  assign f_sum = {1'b0, it_f_r} + {1'b0, FREQ_BIAS};
  assign ovt_f = f_sum[8] ? 8'hFF : f_sum[7:0];
  assign ovt_a = ((it_a_r < OVT_AMP_DN) ? 8'd0 : (it_a_r - OVT_AMP_DN)) | OVT_SQUARE;

  always_comb begin
    cf_we    = 1'b0;
    cf_waddr = IDX_W'(it_ch_r);
    cf_wdata = chan_cfg(it_f_r, it_a_r, adj_r);
    if (state_r == ST_SET_MAIN) begin
      cf_we = 1'b1;
    end else if (state_r == ST_SET_OVT) begin
      cf_we    = 1'b1;
      cf_waddr = IDX_W'(NUM_CHANNELS - 2) + IDX_W'(it_ch_r);
      cf_wdata = chan_cfg(ovt_f, ovt_a, adj_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            state_nxt = ST_TICK;
          end else if (int'(in_tdata[2:0]) < NUM_CHANNELS - 2) begin
            state_nxt = ST_SET_MAIN;
          end
        end
      end
      ST_SET_MAIN: state_nxt = (it_ch_r < OVT_SRC_N) ? ST_SET_OVT : ST_IDLE;
      ST_SET_OVT:  state_nxt = ST_IDLE;
      ST_TICK:     state_nxt = drain_done ? ST_FIN : ST_TICK;
      ST_FIN:      state_nxt = (!out_tvalid_r || out_tready) ? ST_IDLE : ST_FIN;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      adj_r        <= '0;
      cnt_r        <= '0;
      ph_vld_r     <= '0;
      cf_vld_r     <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        adj_r <= cfg_data;
      end
      if (in_acc) begin
        cnt_r <= '0;
        acc_r <= '0;
      end
      if (rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (ph_we) begin
        ph_vld_r[s1_idx_r] <= 1'b1;
      end
      if (cf_we) begin
        cf_vld_r[cf_waddr] <= 1'b1;
      end
      if (s3_v_r) begin
        acc_r <= acc_r + term;
      end
      if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= sample_sat;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      it_ch_r <= in_tdata[2:0];
      it_f_r  <= in_tdata[10:3];
      it_a_r  <= in_tdata[18:11];
    end
    s1_idx_r   <= rd_idx;
    s1_ph_ok_r <= ph_vld_r[rd_idx];
    s1_cf_ok_r <= cf_vld_r[rd_idx];
    dk_r       <= DK_W'(dk_wide);
    gain_r     <= cf_cur.gain;
    prod_r     <= prod;
  end

  wto_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (NUM_CHANNELS)
  ) u_phase_ram (
    .clk   (clk),
    .we    (ph_we),
    .waddr (s1_idx_r),
    .wdata (ph_wdata),
    .raddr (rd_idx),
    .rdata (ph_rdata)
  );

  wto_ram #(
    .WIDTH (CFG_W),
    .DEPTH (NUM_CHANNELS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (rd_idx),
    .rdata (cf_rdata)
  );

  ap_phase_wr_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ph_we |-> (state_r == ST_TICK))
    else $error("phase write outside tick");

  ap_cfg_wr_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cf_we |-> (state_r == ST_SET_MAIN || state_r == ST_SET_OVT))
    else $error("set-up write outside set-up");

  ap_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (cnt_r == CNT_W'(NUM_CHANNELS) && !s1_v_r && !s2_v_r && !s3_v_r))
    else $error("sample issued before pipe drained");

  ap_tick_walks_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK && $past(state_r) == ST_IDLE) |-> (cnt_r == '0))
    else $error("channel walk not restarted");

endmodule
